// ===== sv/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants of the drum step sequencer
// Item and result payloads, command codes, register indexes and the
// command/status bundles between the sequencer controller and datapath.
// ----------------------------------------------------------------------------
package dss_pkg;

	localparam int CMD_W      = 4;
	localparam int TRACK_W    = 4;
	localparam int SIDX_W     = 8;
	localparam int VEL_W      = 7;
	localparam int LOOP_W     = 9;
	localparam int SPB_W      = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	localparam logic [VEL_W-1:0]  TRIG_VEL       = 7'd100;
	localparam logic [VEL_W-1:0]  CLICK_DOWNBEAT = 7'd100;
	localparam logic [VEL_W-1:0]  CLICK_BEAT     = 7'd50;
	localparam logic [LOOP_W-1:0] LOOP_RESET     = 9'd16;
	localparam logic [SPB_W-1:0]  SPB_RESET      = 7'd4;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK         = 4'd0,
		CMD_TRIGGER      = 4'd1,
		CMD_REST         = 4'd2,
		CMD_REST_ALL     = 4'd3,
		CMD_CLEAR_TRACK  = 4'd4,
		CMD_CLEAR_ALL    = 4'd5,
		CMD_SILENCE      = 4'd6,
		CMD_UNSILENCE    = 4'd7,
		CMD_TOGGLE_CLICK = 4'd8,
		CMD_WRITE_STEP   = 4'd9
	} cmd_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOOP_STEPS     = 1'd0,
		REG_STEPS_PER_BEAT = 1'd1
	} cfg_reg_e;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [TRACK_W-1:0] track;
		logic [SIDX_W-1:0]  step_index;
		logic [VEL_W-1:0]   step_velocity;
	} item_t;

	typedef struct packed {
		logic [TRACK_W-1:0] note_track;
		logic [VEL_W-1:0]   note_velocity;
		logic               last_note;
	} result_t;

	typedef struct packed {
		logic load;
		logic tick;
		logic trig;
		logic key_rd;
		logic rmw;
		logic sweep_arm;
		logic sweep;
		logic misc;
		logic div;
		logic play_load;
		logic pop;
	} ctl_t;

	typedef struct packed {
		cmd_e op;
		logic trk_ok;
		logic play;
		logic div_done;
		logic sweep_done;
		logic more;
	} status_t;

endpackage

// ===== sv/dss_ctrl.sv =====
// ----------------------------------------------------------------------------
// dss_ctrl: sequencer controller
// Steps each command through execute, read-modify-write, beat remainder,
// note emission and clearing sweeps; drives the datapath by command bits.
// ----------------------------------------------------------------------------
module dss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dss_pkg::status_t  st,
	output dss_pkg::ctl_t     ctl
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_EXEC  = 6'b000100,
		ST_RMW   = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.sweep = 1'b1;
				if (st.sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				unique case (st.op) inside
					dss_pkg::CMD_TICK: begin
						ctl.tick = 1'b1;
						if (st.play) begin
							state_d = ST_DIV;
						end
					end
					dss_pkg::CMD_TRIGGER: begin
						if (st.trk_ok) begin
							ctl.trig = 1'b1;
							state_d  = ST_EMIT;
						end
					end
					dss_pkg::CMD_REST: begin
						if (st.trk_ok) begin
							ctl.key_rd = 1'b1;
							state_d    = ST_RMW;
						end
					end
					dss_pkg::CMD_REST_ALL: begin
						ctl.key_rd = 1'b1;
						state_d    = ST_RMW;
					end
					dss_pkg::CMD_CLEAR_TRACK: begin
						if (st.trk_ok) begin
							ctl.sweep_arm = 1'b1;
							state_d       = ST_CLEAR;
						end
					end
					dss_pkg::CMD_CLEAR_ALL: begin
						ctl.sweep_arm = 1'b1;
						state_d       = ST_CLEAR;
					end
					dss_pkg::CMD_SILENCE, dss_pkg::CMD_UNSILENCE,
					dss_pkg::CMD_TOGGLE_CLICK, dss_pkg::CMD_WRITE_STEP: begin
						ctl.misc = 1'b1;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_RMW: begin
				ctl.rmw = 1'b1;
				state_d = ST_EMIT;
			end
			ST_DIV: begin
				ctl.div = 1'b1;
				if (st.div_done) begin
					ctl.play_load = 1'b1;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// one note per cycle; leave on the final one
				ctl.pop = 1'b1;
				if (!st.more) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/dss_datapath.sv =====
// ----------------------------------------------------------------------------
// dss_datapath: sequencer datapath
// Counter, settings, silence and click flags, pattern memory (one row of
// track velocities per step), serial beat remainder and note queue.
// ----------------------------------------------------------------------------
module dss_datapath #(
	parameter int MAX_STEPS  = 256,
	parameter int NUM_TRACKS = 9
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dss_pkg::ctl_t                    ctl,
	output dss_pkg::status_t                 st,
	input  dss_pkg::item_t                   item,
	input  logic                             cfg_wr,
	input  logic [dss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dss_pkg::CFG_DATA_W-1:0]   cfg_data,
	output dss_pkg::result_t                 result,
	output logic                             strobe
);

	localparam int STEP_W = $clog2(MAX_STEPS);
	localparam int CNT_W  = STEP_W + 1;
	localparam int LEN_W  = $clog2(MAX_STEPS + 1);
	localparam int TIDX_W = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
	localparam int POS_W  = $clog2(NUM_TRACKS + 1);
	localparam int DC_W   = $clog2(STEP_W);
	localparam int VEL_W  = dss_pkg::VEL_W;
	localparam int SPB_W  = dss_pkg::SPB_W;

	typedef logic [NUM_TRACKS-1:0][VEL_W-1:0] row_t;

	// settings and sequencer state
	logic [dss_pkg::LOOP_W-1:0] loop_q;
	logic [SPB_W-1:0]           spb_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [STEP_W-1:0]          last_step_q;
	logic                       last_valid_q;
	logic [NUM_TRACKS-1:0]      silence_q;
	logic                       click_q;
	dss_pkg::item_t             item_q;

	// beat remainder
	logic [STEP_W-1:0]          step_q;
	logic [SPB_W-1:0]           rem_q;
	logic [DC_W-1:0]            div_cnt_q;

	// pattern memory
	row_t                       mem [MAX_STEPS];
	row_t                       rd_q;
	logic [STEP_W-1:0]          sweep_addr_q;
	logic [NUM_TRACKS-1:0]      sweep_lanes_q;

	// note queue
	logic [NUM_TRACKS:0]        mask_q;
	row_t                       lane_vel_q;
	logic [VEL_W-1:0]           click_vel_q;
	dss_pkg::result_t           result_q;
	logic                       strobe_q;

	// combinational
	logic [LEN_W-1:0]           eff_len;
	logic [SPB_W-1:0]           eff_spb;
	logic [CNT_W:0]             cnt_inc;
	logic [CNT_W:0]             two_len;
	logic [CNT_W-1:0]           cnt_next;
	logic [STEP_W-1:0]          step_next;
	logic                       play;
	logic                       even;
	logic [STEP_W:0]            ks_raw;
	logic [STEP_W-1:0]          key_step;
	logic                       trk_ok;
	logic                       step_ok;
	logic [TIDX_W-1:0]          tidx;
	logic [NUM_TRACKS-1:0]      sel;
	logic                       silenced;
	dss_pkg::cmd_e              op;
	logic [SPB_W:0]             shifted;
	logic [SPB_W:0]             diff;
	logic [SPB_W-1:0]           rem_next;
	logic [NUM_TRACKS-1:0]      nz;
	logic [NUM_TRACKS-1:0]      rmw_lanes;
	logic [POS_W-1:0]           pos;
	logic [NUM_TRACKS:0]        mask_rest;
	logic                       we;
	logic [STEP_W-1:0]          waddr;
	logic [NUM_TRACKS-1:0]      wlanes;
	row_t                       wdata;
	logic                       re;
	logic [STEP_W-1:0]          raddr;

	assign op = dss_pkg::cmd_e'(item_q.cmd);

	always_comb begin
		if (loop_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (int'(loop_q) > MAX_STEPS) begin
			eff_len = LEN_W'(MAX_STEPS);
		end else begin
			eff_len = LEN_W'(loop_q);
		end
	end

	assign eff_spb = (spb_q == '0) ? SPB_W'(1) : spb_q;

	// tick: advance, wrap at twice the loop length
	assign cnt_inc   = {1'b0, cnt_q} + (CNT_W + 1)'(1);
	assign two_len   = (CNT_W + 1)'({eff_len, 1'b0});
	assign cnt_next  = (cnt_inc >= two_len) ? '0 : cnt_inc[CNT_W-1:0];
	assign step_next = cnt_next[CNT_W-1:1];
	assign play      = !last_valid_q || (step_next != last_step_q);

	// key step: round an odd count up, fold out-of-loop steps to zero
	assign even     = ~cnt_q[0];
	assign ks_raw   = (STEP_W + 1)'(cnt_q[CNT_W-1:1]) + (STEP_W + 1)'(cnt_q[0]);
	assign key_step = (ks_raw >= (STEP_W + 1)'(eff_len)) ? '0 : ks_raw[STEP_W-1:0];

	assign trk_ok   = (item_q.track != '0) && (int'(item_q.track) <= NUM_TRACKS);
	assign step_ok  = int'(item_q.step_index) < MAX_STEPS;
	assign tidx     = TIDX_W'(item_q.track - dss_pkg::TRACK_W'(1));
	assign sel      = NUM_TRACKS'(1) << tidx;
	assign silenced = silence_q[tidx];

	// one restoring remainder step per cycle, MSB of the step first
	assign shifted  = {rem_q, step_q[div_cnt_q]};
	assign diff     = shifted - {1'b0, eff_spb};
	assign rem_next = (shifted >= {1'b0, eff_spb}) ? diff[SPB_W-1:0] : shifted[SPB_W-1:0];

	always_comb begin
		for (int i = 0; i < NUM_TRACKS; i++) begin
			nz[i] = (rd_q[i] != '0);
		end
	end

	assign rmw_lanes = (op == dss_pkg::CMD_REST_ALL) ? '1 : sel;

	// lowest pending note first; the click sits above all tracks
	always_comb begin
		pos = '0;
		for (int i = NUM_TRACKS; i >= 0; i--) begin
			if (mask_q[i]) begin
				pos = POS_W'(i);
			end
		end
	end

	assign mask_rest = mask_q & ~((NUM_TRACKS + 1)'(1) << pos);

	// memory port select
	always_comb begin
		we     = 1'b0;
		waddr  = key_step;
		wlanes = sel;
		wdata  = {NUM_TRACKS{dss_pkg::TRIG_VEL}};
		if (ctl.sweep) begin
			we     = 1'b1;
			waddr  = sweep_addr_q;
			wlanes = sweep_lanes_q;
			wdata  = '0;
		end else if (ctl.trig) begin
			we = !silenced;
		end else if (ctl.rmw) begin
			we     = 1'b1;
			wlanes = rmw_lanes;
			wdata  = '0;
		end else if (ctl.misc && (op == dss_pkg::CMD_WRITE_STEP) && trk_ok && step_ok) begin
			we    = 1'b1;
			waddr = STEP_W'(item_q.step_index);
			wdata = {NUM_TRACKS{item_q.step_velocity}};
		end
	end

	assign re    = ctl.tick | ctl.key_rd;
	assign raddr = ctl.tick ? step_next : key_step;

	always_ff @(posedge clk) begin
		if (we) begin
			for (int i = 0; i < NUM_TRACKS; i++) begin
				if (wlanes[i]) begin
					mem[waddr][i] <= wdata[i];
				end
			end
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q        <= dss_pkg::LOOP_RESET;
			spb_q         <= dss_pkg::SPB_RESET;
			cnt_q         <= '0;
			last_valid_q  <= 1'b0;
			silence_q     <= '0;
			click_q       <= 1'b0;
			sweep_addr_q  <= '0;
			sweep_lanes_q <= '1;
			mask_q        <= '0;
			strobe_q      <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (dss_pkg::cfg_reg_e'(cfg_index))
					dss_pkg::REG_LOOP_STEPS:     loop_q <= cfg_data[dss_pkg::LOOP_W-1:0];
					dss_pkg::REG_STEPS_PER_BEAT: spb_q  <= cfg_data[SPB_W-1:0];
					default: ;
				endcase
			end
			if (ctl.tick) begin
				cnt_q <= cnt_next;
				if (play) begin
					last_valid_q <= 1'b1;
				end
			end
			if (ctl.misc) begin
				case (op)
					dss_pkg::CMD_SILENCE: begin
						if (trk_ok) begin
							silence_q[tidx] <= 1'b1;
						end
					end
					dss_pkg::CMD_UNSILENCE: begin
						if (trk_ok) begin
							silence_q[tidx] <= 1'b0;
						end
					end
					dss_pkg::CMD_TOGGLE_CLICK: begin
						click_q <= ~click_q;
					end
					default: ;
				endcase
			end
			if (ctl.sweep_arm) begin
				sweep_addr_q  <= '0;
				sweep_lanes_q <= (op == dss_pkg::CMD_CLEAR_ALL) ? '1 : sel;
			end else if (ctl.sweep) begin
				sweep_addr_q <= sweep_addr_q + STEP_W'(1);
			end
			if (ctl.pop) begin
				mask_q <= mask_rest;
			end else if (ctl.play_load) begin
				mask_q <= {click_q && (rem_next == '0), nz & ~silence_q};
			end else if (ctl.trig) begin
				mask_q <= (silenced || even) ? {1'b0, sel} : '0;
			end else if (ctl.rmw) begin
				mask_q <= even ? {1'b0, nz & rmw_lanes} : '0;
			end
			strobe_q <= ctl.pop && (mask_q != '0);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= item;
		end
		if (ctl.tick && play) begin
			last_step_q <= step_next;
			step_q      <= step_next;
			rem_q       <= '0;
			div_cnt_q   <= DC_W'(STEP_W - 1);
		end else if (ctl.div) begin
			rem_q     <= rem_next;
			div_cnt_q <= div_cnt_q - DC_W'(1);
		end
		if (ctl.play_load) begin
			lane_vel_q  <= rd_q;
			click_vel_q <= (step_q == '0) ? dss_pkg::CLICK_DOWNBEAT : dss_pkg::CLICK_BEAT;
		end else if (ctl.trig) begin
			lane_vel_q <= {NUM_TRACKS{dss_pkg::TRIG_VEL}};
		end else if (ctl.rmw) begin
			lane_vel_q <= '0;
		end
		if (ctl.pop) begin
			if (int'(pos) == NUM_TRACKS) begin
				result_q.note_track    <= '0;
				result_q.note_velocity <= click_vel_q;
			end else begin
				result_q.note_track    <= dss_pkg::TRACK_W'(pos) + dss_pkg::TRACK_W'(1);
				result_q.note_velocity <= lane_vel_q[TIDX_W'(pos)];
			end
			result_q.last_note <= (mask_rest == '0);
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;

	always_comb begin
		st            = '0;
		st.op         = op;
		st.trk_ok     = trk_ok;
		st.play       = play;
		st.div_done   = (div_cnt_q == '0);
		st.sweep_done = (sweep_addr_q == STEP_W'(MAX_STEPS - 1));
		st.more       = (mask_q & (mask_q - (NUM_TRACKS + 1)'(1))) != '0;
	end

endmodule

// ===== sv/drum_step_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// drum_step_sequencer_core: multi-track drum step sequencer
// Ticks play the stored pattern; key commands record, erase, clear, silence and edit it.
// Command channel: a transaction is taken on an edge where start is high and
// busy is low; busy stays high until every note of the command is sent.
// Results: one note per strobe cycle, last_note on the final one. The receiver
// cannot stall, so it must take every strobe. Config: cfg_valid/cfg_ready
// (always ready); write only while no command is in flight.
// Command flow (STEP_W = clog2(MAX_STEPS), 8 by default); the
// next transaction is taken at the end of the first cycle with busy low:
//   a tick on no new step sends no note; a tick on a new step runs the
//   serial beat remainder over the STEP_W step bits, then one note per cycle;
//   trigger goes straight to its notes; rest and rest all pass through a
//   read-modify-write first; clear sweeps all MAX_STEPS rows; others only
//   execute. Tracks go in order, click last.
// Reset: settings return to defaults and a sweep over all MAX_STEPS rows
// clears the pattern memory with busy high; config writes are taken meanwhile.
// ----------------------------------------------------------------------------
module drum_step_sequencer_core #(
	parameter int MAX_STEPS  = 256,
	parameter int NUM_TRACKS = 9
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  dss_pkg::item_t                  item,
	output dss_pkg::result_t                result,
	output logic                            strobe,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dss_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dss_pkg::CFG_DATA_W-1:0]  cfg_data
);

	dss_pkg::ctl_t    ctl;
	dss_pkg::status_t st;

	assign cfg_ready = 1'b1;

	dss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.ctl    (ctl)
	);

	dss_datapath #(
		.MAX_STEPS  (MAX_STEPS),
		.NUM_TRACKS (NUM_TRACKS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.st        (st),
		.item      (item),
		.cfg_wr    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result),
		.strobe    (strobe)
	);

endmodule

// ===== bench/tb_drum_step_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// tb_drum_step_sequencer_core: self-checking bench for the drum step sequencer
// A queue of commands and register writes feeds a clocked driver; a
// behavioral copy of the sequencer predicts every note, and a clocked
// monitor compares each strobed note with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_drum_step_sequencer_core;

	localparam int N_TRACKS      = 9;
	localparam int N_STEPS       = 256;
	localparam int SETTLE_CYCLES = 32;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int ITEM_TARGET   = 370;

	typedef enum logic [1:0] {
		JOB_CMD,
		JOB_CFG,
		JOB_DRAIN
	} job_kind_e;

	typedef struct packed {
		job_kind_e                      kind;
		dss_pkg::item_t                 cmd_item;
		dss_pkg::cfg_reg_e              reg_sel;
		logic [dss_pkg::CFG_DATA_W-1:0] reg_data;
	} job_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	dss_pkg::item_t                 item;
	dss_pkg::result_t               result;
	logic                           strobe;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dss_pkg::CFG_DATA_W-1:0] cfg_data;

	// stimulus and expectations
	job_t             jobs[$];
	dss_pkg::result_t pending_notes[$];

	// sequencer state as seen by the note predictor
	logic [dss_pkg::VEL_W-1:0]  grid [1:N_TRACKS][0:N_STEPS-1];
	logic [dss_pkg::LOOP_W-1:0] loop_reg;
	logic [dss_pkg::SPB_W-1:0]  spb_reg;
	int                         half_ticks;
	int                         last_played;
	logic [N_TRACKS:1]          muted;
	logic                       click_on;

	dss_pkg::result_t burst [0:15];
	int               burst_n;

	int mismatches    = 0;
	int cmds_sent     = 0;
	int notes_checked = 0;
	int cfg_writes    = 0;
	int cycles        = 0;
	int idle_left;
	int no_gap_left;
	int quiet;
	int counted;

	drum_step_sequencer_core #(
		.MAX_STEPS (N_STEPS),
		.NUM_TRACKS(N_TRACKS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.result   (result),
		.strobe   (strobe),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) begin
			$display("MISMATCH @%0d: %s", cycles, msg);
		end
	endtask

	function automatic int loop_len();
		if (loop_reg == 0) return 1;
		if (loop_reg > N_STEPS) return N_STEPS;
		return int'(loop_reg);
	endfunction

	function automatic int beat_len();
		return (spb_reg == 0) ? 1 : int'(spb_reg);
	endfunction

	// step a key event lands on; odd counters round up to the next step
	function automatic int key_step(output bit even);
		int c;
		c = half_ticks;
		even = (c % 2) == 0;
		if (!even) c++;
		c = c / 2;
		if (c >= loop_len()) c = 0;
		return c;
	endfunction

	task automatic note_out(input int trk, input logic [dss_pkg::VEL_W-1:0] vel);
		burst[burst_n] = '{note_track: trk[dss_pkg::TRACK_W-1:0], note_velocity: vel,
			last_note: 1'b0};
		burst_n++;
	endtask

	task automatic wipe_grid();
		for (int t = 1; t <= N_TRACKS; t++) begin
			for (int s = 0; s < N_STEPS; s++) grid[t][s] = '0;
		end
	endtask

	task automatic erase_step(input int trk);
		bit even;
		int s;
		s = key_step(even);
		if (even && grid[trk][s] != 0) note_out(trk, '0);
		grid[trk][s] = '0;
	endtask

	task automatic play_tick();
		int len;
		int step;
		len = loop_len();
		half_ticks++;
		if (half_ticks >= 2 * len) half_ticks = 0;
		step = half_ticks / 2;
		if (step == last_played) return;
		last_played = step;
		for (int t = 1; t <= N_TRACKS; t++) begin
			if (grid[t][step] != 0 && !muted[t]) note_out(t, grid[t][step]);
		end
		if (click_on && (step % beat_len()) == 0) begin
			note_out(0, (step == 0) ? dss_pkg::CLICK_DOWNBEAT : dss_pkg::CLICK_BEAT);
		end
	endtask

	task automatic predict_notes(input dss_pkg::item_t it);
		int  trk;
		int  s;
		bit  even;
		bit  trk_ok;
		trk     = int'(it.track);
		trk_ok  = trk >= 1 && trk <= N_TRACKS;
		burst_n = 0;
		case (it.cmd)
			dss_pkg::CMD_TICK: begin
				play_tick();
			end
			dss_pkg::CMD_TRIGGER: begin
				if (trk_ok) begin
					if (muted[trk]) begin
						note_out(trk, dss_pkg::TRIG_VEL);
					end else begin
						s = key_step(even);
						if (even) note_out(trk, dss_pkg::TRIG_VEL);
						grid[trk][s] = dss_pkg::TRIG_VEL;
					end
				end
			end
			dss_pkg::CMD_REST: begin
				if (trk_ok) erase_step(trk);
			end
			dss_pkg::CMD_REST_ALL: begin
				for (int t = 1; t <= N_TRACKS; t++) erase_step(t);
			end
			dss_pkg::CMD_CLEAR_TRACK: begin
				if (trk_ok) begin
					for (int k = 0; k < N_STEPS; k++) grid[trk][k] = '0;
				end
			end
			dss_pkg::CMD_CLEAR_ALL: begin
				wipe_grid();
			end
			dss_pkg::CMD_SILENCE: begin
				if (trk_ok) muted[trk] = 1'b1;
			end
			dss_pkg::CMD_UNSILENCE: begin
				if (trk_ok) muted[trk] = 1'b0;
			end
			dss_pkg::CMD_TOGGLE_CLICK: begin
				click_on = ~click_on;
			end
			dss_pkg::CMD_WRITE_STEP: begin
				if (trk_ok && int'(it.step_index) < N_STEPS) begin
					grid[trk][it.step_index] = it.step_velocity;
				end
			end
			default: begin
			end
		endcase
		for (int i = 0; i < burst_n; i++) begin
			burst[i].last_note = (i == burst_n - 1);
			pending_notes.push_back(burst[i]);
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (no_gap_left > 0) begin
			no_gap_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			no_gap_left = $urandom_range(10, 30);
			return 0;
		end
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic add_cmd(input logic [dss_pkg::CMD_W-1:0] cmd,
		input logic [dss_pkg::TRACK_W-1:0] trk,
		input logic [dss_pkg::SIDX_W-1:0] idx, input logic [dss_pkg::VEL_W-1:0] vel);
		job_t j;
		j          = '0;
		j.kind     = JOB_CMD;
		j.cmd_item = '{cmd: cmd, track: trk, step_index: idx, step_velocity: vel};
		jobs.push_back(j);
	endtask

	task automatic add_cfg(input dss_pkg::cfg_reg_e sel,
		input logic [dss_pkg::CFG_DATA_W-1:0] data);
		job_t j;
		j          = '0;
		j.kind     = JOB_CFG;
		j.reg_sel  = sel;
		j.reg_data = data;
		jobs.push_back(j);
	endtask

	task automatic add_drain();
		job_t j;
		j      = '0;
		j.kind = JOB_DRAIN;
		jobs.push_back(j);
	endtask

	function automatic logic [dss_pkg::TRACK_W-1:0] pick_track();
		if ($urandom_range(0, 9) != 0) begin
			return dss_pkg::TRACK_W'($urandom_range(1, N_TRACKS));
		end
		return ($urandom_range(0, 1) != 0) ? '0 :
			dss_pkg::TRACK_W'($urandom_range(N_TRACKS + 1, 15));
	endfunction

	// random commands for one register setting; loop length biases step indexes
	task automatic add_random_cmds(input int n, input int len);
		int                          r;
		int                          made;
		logic [dss_pkg::CMD_W-1:0]   cmd;
		logic [dss_pkg::SIDX_W-1:0]  idx;
		logic [dss_pkg::VEL_W-1:0]   vel;
		made = 0;
		while (made < n) begin
			r   = $urandom_range(0, 99);
			idx = dss_pkg::SIDX_W'($urandom);
			vel = dss_pkg::VEL_W'($urandom);
			if (r < 45)      cmd = dss_pkg::CMD_TICK;
			else if (r < 60) cmd = dss_pkg::CMD_TRIGGER;
			else if (r < 68) cmd = dss_pkg::CMD_REST;
			else if (r < 70) cmd = dss_pkg::CMD_REST_ALL;
			else if (r < 71) cmd = dss_pkg::CMD_CLEAR_TRACK;
			else if (r < 72) cmd = dss_pkg::CMD_CLEAR_ALL;
			else if (r < 76) cmd = dss_pkg::CMD_SILENCE;
			else if (r < 81) cmd = dss_pkg::CMD_UNSILENCE;
			else if (r < 84) cmd = dss_pkg::CMD_TOGGLE_CLICK;
			else if (r < 97) cmd = dss_pkg::CMD_WRITE_STEP;
			else             cmd = dss_pkg::CMD_W'($urandom_range(10, 15));
			if (cmd == dss_pkg::CMD_WRITE_STEP) begin
				if ($urandom_range(0, 4) != 0) begin
					idx = dss_pkg::SIDX_W'($urandom_range(0, len - 1));
				end
				if ($urandom_range(0, 9) == 0) vel = '0;
			end
			add_cmd(cmd, pick_track(), idx, vel);
			if (cmd <= dss_pkg::CMD_WRITE_STEP) made++;
			if ($urandom_range(0, 49) == 0) add_drain();
		end
		counted += made;
	endtask

	// command and register-write driver
	always @(posedge clk) begin : drive_cmds
		logic nxt_start;
		logic nxt_cfg;
		job_t job;
		if (!arst_n) begin
			start       <= 1'b0;
			item        <= '0;
			cfg_valid   <= 1'b0;
			cfg_index   <= '0;
			cfg_data    <= '0;
			idle_left   = 0;
			no_gap_left = 0;
			quiet       = 0;
			loop_reg    = dss_pkg::LOOP_RESET;
			spb_reg     = dss_pkg::SPB_RESET;
			half_ticks  = 0;
			last_played = -1;
			muted       = '0;
			click_on    = 1'b0;
			wipe_grid();
		end else begin
			if (!busy && !start && !cfg_valid && !strobe && pending_notes.size() == 0) begin
				quiet++;
			end else begin
				quiet = 0;
			end
			nxt_start = start;
			nxt_cfg   = cfg_valid;
			if (start && !busy) begin
				predict_notes(item);
				cmds_sent++;
				nxt_start = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == dss_pkg::REG_LOOP_STEPS) begin
					loop_reg = cfg_data[dss_pkg::LOOP_W-1:0];
				end else begin
					spb_reg  = cfg_data[dss_pkg::SPB_W-1:0];
				end
				cfg_writes++;
				nxt_cfg = 1'b0;
			end
			if (!nxt_start && !nxt_cfg) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (jobs.size() != 0) begin
					job = jobs[0];
					case (job.kind)
						JOB_CMD: begin
							item      <= job.cmd_item;
							nxt_start = 1'b1;
							idle_left = pick_gap();
							void'(jobs.pop_front());
						end
						JOB_CFG: begin
							// write only once the block has gone quiet
							if (quiet >= SETTLE_CYCLES) begin
								cfg_index <= job.reg_sel;
								cfg_data  <= job.reg_data;
								nxt_cfg   = 1'b1;
								void'(jobs.pop_front());
							end
						end
						default: begin
							if (quiet >= SETTLE_CYCLES) void'(jobs.pop_front());
						end
					endcase
				end
			end
			start     <= nxt_start;
			cfg_valid <= nxt_cfg;
		end
	end

	// note monitor
	always @(posedge clk) begin : watch_notes
		dss_pkg::result_t want;
		if (arst_n && strobe) begin
			if (pending_notes.size() == 0) begin
				report_mismatch($sformatf("unexpected note track %0d vel %0d last %0d",
					result.note_track, result.note_velocity, result.last_note));
			end else begin
				want = pending_notes.pop_front();
				notes_checked++;
				if (result !== want) begin
					report_mismatch($sformatf("note got trk %0d vel %0d last %0d, want %0d %0d %0d",
						result.note_track, result.note_velocity, result.last_note,
						want.note_track, want.note_velocity, want.last_note));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_drum_step_sequencer_core failed");
			$finish;
		end
	end

	initial begin
		int lens [0:7];
		int spbs [0:7];
		int eff;
		int waited;
		arst_n  = 1'b0;
		counted = 0;

		// directed opening at the reset loop of 16 steps, 4 per beat
		add_cmd(dss_pkg::CMD_TOGGLE_CLICK, 4'd0, 8'd0, 7'd0);
		add_cmd(dss_pkg::CMD_TICK, 4'd0, 8'hFF, 7'h7F);          // downbeat click
		add_cmd(dss_pkg::CMD_TRIGGER, 4'd1, 8'd0, 7'd0);         // odd counter: stored only
		add_cmd(dss_pkg::CMD_TICK, 4'd0, 8'd0, 7'd0);
		add_cmd(dss_pkg::CMD_TRIGGER, 4'd9, 8'd0, 7'd0);         // even counter: sounds now
		add_cmd(dss_pkg::CMD_WRITE_STEP, 4'd5, 8'd1, 7'd127);
		add_cmd(dss_pkg::CMD_WRITE_STEP, 4'd3, 8'd255, 7'd1);
		add_cmd(dss_pkg::CMD_SILENCE, 4'd5, 8'd0, 7'd0);
		add_cmd(dss_pkg::CMD_TRIGGER, 4'd5, 8'd0, 7'd0);         // muted: sounds, not stored
		add_cmd(dss_pkg::CMD_REST, 4'd9, 8'd0, 7'd0);            // note-off for stored step
		add_cmd(dss_pkg::CMD_REST, 4'd2, 8'd0, 7'd0);
		add_cmd(dss_pkg::CMD_TICK, 4'd0, 8'd0, 7'd0);            // same step: silent
		add_cmd(dss_pkg::CMD_TICK, 4'd0, 8'd0, 7'd0);
		add_cmd(dss_pkg::CMD_WRITE_STEP, 4'd0, 8'd2, 7'd5);      // bad track
		add_cmd(dss_pkg::CMD_TRIGGER, 4'd15, 8'd0, 7'd0);
		add_cmd(4'd15, 4'd1, 8'd0, 7'd0);                        // unused command
		add_cmd(dss_pkg::CMD_UNSILENCE, 4'd5, 8'd0, 7'd0);
		add_cmd(dss_pkg::CMD_WRITE_STEP, 4'd4, 8'd2, 7'd64);
		add_cmd(dss_pkg::CMD_WRITE_STEP, 4'd9, 8'd2, 7'd80);
		add_cmd(dss_pkg::CMD_SILENCE, 4'd9, 8'd0, 7'd0);
		add_cmd(dss_pkg::CMD_REST_ALL, 4'd0, 8'd0, 7'd0);        // muted track still sends note-off
		add_cmd(dss_pkg::CMD_CLEAR_TRACK, 4'd1, 8'd0, 7'd0);
		add_cmd(dss_pkg::CMD_CLEAR_ALL, 4'd0, 8'd0, 7'd0);
		add_cmd(dss_pkg::CMD_TOGGLE_CLICK, 4'd0, 8'd0, 7'd0);
		counted = 24;

		// register settings: extremes, out-of-range values and loop shrinks
		lens = '{1, 256, 5, 0, 511, 2, 12, 16};
		spbs = '{1, 100, 3, 0, 9'h1FF, 2, 4, 4};
		for (int p = 0; p < 8; p++) begin
			add_drain();
			add_cfg(dss_pkg::REG_LOOP_STEPS, dss_pkg::CFG_DATA_W'(lens[p]));
			add_cfg(dss_pkg::REG_STEPS_PER_BEAT, dss_pkg::CFG_DATA_W'(spbs[p]));
			eff = (lens[p] == 0) ? 1 : (lens[p] > N_STEPS ? N_STEPS : lens[p]);
			add_random_cmds((ITEM_TARGET - counted) / (8 - p), eff);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (jobs.size() != 0 || start || cfg_valid || busy) @(posedge clk);
		waited = 0;
		while (pending_notes.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_notes.size() != 0) begin
			report_mismatch($sformatf("%0d expected notes never arrived", pending_notes.size()));
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d commands, %0d register writes, %0d notes compared",
			cmds_sent, cfg_writes, notes_checked);
		$display("Loop lengths 1..256 incl. out-of-range and shrinks; %0d mismatches",
			mismatches);
		if (mismatches == 0) begin
			$display("tb_drum_step_sequencer_core passed");
		end else begin
			$display("tb_drum_step_sequencer_core failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/dss_pkg.sv
sv/dss_ctrl.sv
sv/dss_datapath.sv
sv/drum_step_sequencer_core.sv
bench/tb_drum_step_sequencer_core.sv
